// ===== sv/marp_pkg.sv =====
// Arpeggiator step engine: shared types, widths and constants.
// No dependencies.
`default_nettype none
package marp_pkg;
   localparam int NOTE_W     = 7;
   localparam int SAMP_W     = 14;
   localparam int OFF_W      = 13;
   localparam int VEL_W      = 7;
   localparam int STEP_W     = 24;
   localparam int SWING_W    = 8;
   localparam int GATE_W     = 9;
   localparam int VLEN_W     = 4;
   localparam int DUR_W      = 25;
   localparam int MOD_W      = 26;
   localparam int LFSR_W     = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 56;

   localparam logic [SAMP_W-1:0] MAX_BLOCK  = 14'd8192;
   localparam logic [LFSR_W-1:0] LFSR_SEED  = 16'hACE1;
   localparam logic [LFSR_W-1:0] LFSR_TAPS  = 16'hB400;
   localparam logic [STEP_W-1:0] STEP_RESET = 24'd5512;
   localparam logic [GATE_W-1:0] GATE_RESET = 9'd205;

   typedef enum logic [1:0] {
      OP_NOTE_ON  = 2'd0,
      OP_NOTE_OFF = 2'd1,
      OP_TICK     = 2'd2,
      OP_CLEAR    = 2'd3
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ARP_ORDER   = 3'd0,
      CSR_HOLD_NOTES  = 3'd1,
      CSR_STEP        = 3'd2,
      CSR_SWING       = 3'd3,
      CSR_GATE        = 3'd4,
      CSR_VEL_LEN     = 3'd5,
      CSR_VEL_PATTERN = 3'd6
   } csr_idx_type;

   localparam logic [2:0] ORD_UP     = 3'd0;
   localparam logic [2:0] ORD_DOWN   = 3'd1;
   localparam logic [2:0] ORD_UPDOWN = 3'd2;
   localparam logic [2:0] ORD_RANDOM = 3'd3;
   localparam logic [2:0] ORD_CHORD  = 3'd4;

   typedef struct packed {
      op_type              op;
      logic [NOTE_W-1:0]   note;
      logic                note_ok;
      logic [SAMP_W-1:0]   samples;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_type;

   typedef struct packed {
      logic                  we;
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] data;
   } csr_type;

   typedef struct packed {
      logic             start;
      logic [MOD_W-1:0] dividend;
      logic [DUR_W-1:0] divisor;
   } mod_req_type;

   typedef struct packed {
      logic             done;
      logic [DUR_W-1:0] rem;
   } mod_rsp_type;
endpackage
`default_nettype wire

// ===== sv/marp_req_if.sv =====
// Request channel: note, tick and clear words.
// Depends on marp_pkg.
`default_nettype none
interface marp_req_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    mode;
   logic [marp_pkg::NOTE_W-1:0]   note_number;
   logic [marp_pkg::SAMP_W-1:0]   block_samples;
   modport source (output valid, mode, note_number, block_samples, input ready);
   modport sink   (input valid, mode, note_number, block_samples, output ready);
endinterface
`default_nettype wire

// ===== sv/marp_rsp_if.sv =====
// Response channel: MIDI event words.
// Depends on marp_pkg.
`default_nettype none
interface marp_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         event_kind;
   logic [marp_pkg::NOTE_W-1:0]  event_note;
   logic [marp_pkg::VEL_W-1:0]   event_velocity;
   logic [marp_pkg::OFF_W-1:0]   sample_offset;
   logic                         last_event;
   modport source (output valid, event_kind, event_note, event_velocity, sample_offset,
                   last_event, input ready);
   modport sink   (input valid, event_kind, event_note, event_velocity, sample_offset,
                   last_event, output ready);
endinterface
`default_nettype wire

// ===== sv/marp_front.sv =====
// Front end: accepts request words, decodes them, holds them in a 2-entry queue.
// Depends on marp_pkg, marp_req_if.
`default_nettype none
module marp_front #(
   parameter int NOTE_COUNT = 128
) (
   input  wire                  clock,
   input  wire                  reset,
   marp_req_if.sink             req_ch,
   input  wire                  pop,
   output marp_pkg::queue_type  head
);
   marp_pkg::item_type q_ff [2];
   marp_pkg::item_type q_in [2];
   logic       wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       push;
   marp_pkg::item_type dec;

   assign req_ch.ready = (fill_ff != 2'd2);
   assign push = req_ch.valid && req_ch.ready;
   assign head.valid = (fill_ff != 2'd0);
   assign head.item  = q_ff[rptr_ff];

   always_comb begin
      dec.op      = marp_pkg::op_type'(req_ch.mode);
      dec.note    = req_ch.note_number;
      dec.note_ok = (32'(req_ch.note_number) < NOTE_COUNT);
      dec.samples = (req_ch.block_samples > marp_pkg::MAX_BLOCK) ?
                    marp_pkg::MAX_BLOCK : req_ch.block_samples;
   end

   always_comb begin
      q_in    = q_ff;
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      fill_in = fill_ff;
      if (push) begin
         q_in[wptr_ff] = dec;
         wptr_in = ~wptr_ff;
      end
      if (pop && head.valid) begin
         rptr_in = ~rptr_ff;
      end
      fill_in = fill_ff + {1'b0, push} - {1'b0, pop && head.valid};
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         fill_ff <= fill_in;
      end
   end
endmodule
`default_nettype wire

// ===== sv/marp_mod.sv =====
// Shared restoring remainder unit, one quotient bit per cycle.
// Depends on marp_pkg.
`default_nettype none
module marp_mod (
   input  wire                    clock,
   input  wire                    reset,
   input  marp_pkg::mod_req_type  req,
   output marp_pkg::mod_rsp_type  rsp
);
   localparam int CNT_W = $clog2(marp_pkg::MOD_W);

   logic                          busy_ff, busy_in, done_ff, done_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic [marp_pkg::MOD_W-1:0]    dvd_ff, dvd_in;
   logic [marp_pkg::DUR_W-1:0]    dvs_ff, dvs_in, rem_ff, rem_in;
   logic [marp_pkg::MOD_W-1:0]    trial;

   assign rsp.done = done_ff;
   assign rsp.rem  = rem_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      trial   = {rem_ff, dvd_ff[marp_pkg::MOD_W-1]};
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = req.dividend;
         dvs_in  = req.divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[marp_pkg::MOD_W-2:0], 1'b0};
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = marp_pkg::DUR_W'(trial - {1'b0, dvs_ff});
         end else begin
            rem_in = marp_pkg::DUR_W'(trial);
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(marp_pkg::MOD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end
endmodule
`default_nettype wire

// ===== sv/marp_back.sv =====
// Back end: held-note set, step timing, note selection and event output register.
// Depends on marp_pkg, marp_rsp_if, marp_mod.
`default_nettype none
module marp_back #(
   parameter int NOTE_COUNT        = 128,
   parameter int VEL_PATTERN_DEPTH = 8
) (
   input  wire                  clock,
   input  wire                  reset,
   input  marp_pkg::queue_type  head,
   output logic                 pop,
   input  marp_pkg::csr_type    csr,
   marp_rsp_if.source           rsp_ch
);
   localparam int CHUNKS = (NOTE_COUNT + 7) / 8;
   localparam int PAD    = CHUNKS * 8;
   localparam int IDX_W  = $clog2(PAD);
   localparam int CH_W   = $clog2(CHUNKS);
   localparam int CNT_W  = $clog2(NOTE_COUNT + 1);
   localparam int VPW    = VEL_PATTERN_DEPTH * 7;
   localparam int NW     = marp_pkg::NOTE_W;
   localparam int DW     = marp_pkg::DUR_W;
   localparam int OW     = marp_pkg::OFF_W;
   localparam int VLEN_W_L = marp_pkg::VLEN_W;

   typedef enum logic [13:0] {
      ST_IDLE  = 14'b00000000000001,
      ST_EMPTY = 14'b00000000000010,
      ST_DUR   = 14'b00000000000100,
      ST_GATE  = 14'b00000000001000,
      ST_OFF1  = 14'b00000000010000,
      ST_ADV   = 14'b00000000100000,
      ST_MODW  = 14'b00000001000000,
      ST_POS   = 14'b00000010000000,
      ST_VELW  = 14'b00000100000000,
      ST_SCAN  = 14'b00001000000000,
      ST_ON    = 14'b00010000000000,
      ST_GOFF  = 14'b00100000000000,
      ST_ACC   = 14'b01000000000000,
      ST_ACCW  = 14'b10000000000000
   } state_type;

   state_type st_ff, st_in;
   logic [2:0]                       order_ff, order_in;
   logic                             hold_ff, hold_in;
   logic [marp_pkg::STEP_W-1:0]      step_ff, step_in;
   logic [marp_pkg::SWING_W-1:0]     swing_ff, swing_in;
   logic [marp_pkg::GATE_W-1:0]      gate_ff, gate_in;
   logic [marp_pkg::VLEN_W-1:0]      vlen_ff, vlen_in;
   logic [VPW-1:0]                   vpat_ff, vpat_in;
   logic [PAD-1:0]                   held_ff, held_in;
   logic [CNT_W-1:0]                 cnt_ff, cnt_in;
   logic [NW-1:0]                    idx_ff, idx_in;
   logic                             down_ff, down_in;
   logic                             snd_ok_ff, snd_ok_in;
   logic [NW-1:0]                    snd_ff, snd_in;
   logic [DW-1:0]                    accum_ff, accum_in;
   logic [marp_pkg::LFSR_W-1:0]      lfsr_ff, lfsr_in;
   logic [marp_pkg::SAMP_W-1:0]      n_ff, n_in;
   logic [DW-1:0]                    dur_ff, dur_in, gdur_ff, gdur_in;
   logic [marp_pkg::MOD_W-1:0]       sum_ff, sum_in;
   logic [OW-1:0]                    off_ff, off_in;
   logic                             gated_ff, gated_in;
   logic [CH_W-1:0]                  chunk_ff, chunk_in;
   logic [NW-1:0]                    k_ff, k_in;
   logic [marp_pkg::VEL_W-1:0]       vel_ff, vel_in;
   logic                             ov_ff, ov_in, okind_ff, okind_in, olast_ff, olast_in;
   logic [NW-1:0]                    onote_ff, onote_in;
   logic [marp_pkg::VEL_W-1:0]       ovel_ff, ovel_in;
   logic [OW-1:0]                    ooff_ff, ooff_in;

   marp_pkg::mod_req_type mreq;
   marp_pkg::mod_rsp_type mrsp;

   logic                      out_free;
   logic [IDX_W-1:0]          nidx;
   logic [CNT_W-1:0]          cnt_m1, cnt_after;
   logic [marp_pkg::STEP_W-1:0] base;
   logic [8:0]                mult9;
   logic [33:0]               prod;
   logic [DW-1:0]             dnew, diff;
   logic [marp_pkg::GATE_W-1:0] gclamp;
   logic [marp_pkg::SAMP_W-1:0] nm1;
   logic signed [8:0]         ud_t;
   logic [marp_pkg::LFSR_W-1:0] lfsr_nx;
   logic [VLEN_W_L-1:0]       vlen_c;
   logic [2:0]                ent;
   logic [6:0]                vraw;
   logic [7:0]                bits;
   logic [3:0]                pc, seen;
   logic [2:0]                hit;
   logic [marp_pkg::MOD_W-1:0] gsum;

   marp_mod u_mod (.clock(clock), .reset(reset), .req(mreq), .rsp(mrsp));

   assign out_free = !ov_ff || rsp_ch.ready;
   assign nidx     = head.item.note[IDX_W-1:0];
   assign cnt_m1   = cnt_ff - 1'b1;

   assign rsp_ch.valid          = ov_ff;
   assign rsp_ch.event_kind     = okind_ff;
   assign rsp_ch.event_note     = onote_ff;
   assign rsp_ch.event_velocity = ovel_ff;
   assign rsp_ch.sample_offset  = ooff_ff;
   assign rsp_ch.last_event     = olast_ff;

   always_comb begin
      st_in = st_ff;   order_in = order_ff; hold_in = hold_ff; step_in = step_ff;
      swing_in = swing_ff; gate_in = gate_ff; vlen_in = vlen_ff; vpat_in = vpat_ff;
      held_in = held_ff; cnt_in = cnt_ff; idx_in = idx_ff; down_in = down_ff;
      snd_ok_in = snd_ok_ff; snd_in = snd_ff; accum_in = accum_ff; lfsr_in = lfsr_ff;
      n_in = n_ff; dur_in = dur_ff; gdur_in = gdur_ff; sum_in = sum_ff; off_in = off_ff;
      gated_in = gated_ff; chunk_in = chunk_ff; k_in = k_ff; vel_in = vel_ff;
      ov_in = ov_ff; okind_in = okind_ff; olast_in = olast_ff; onote_in = onote_ff;
      ovel_in = ovel_ff; ooff_in = ooff_ff;
      pop = 1'b0;
      mreq = '0;
      cnt_after = cnt_ff;
      base  = (step_ff == '0) ? marp_pkg::STEP_W'(1) : step_ff;
      mult9 = idx_ff[0] ? (9'd256 + 9'(swing_ff)) : (9'd256 - 9'(swing_ff));
      prod  = 34'(base) * 34'(mult9);
      dnew  = DW'(prod >> 8);
      gclamp = (gate_ff == '0) ? 9'd1 : ((gate_ff > 9'd256) ? 9'd256 : gate_ff);
      diff  = (dur_ff > accum_ff) ? (dur_ff - accum_ff) : '0;
      nm1   = n_ff - 1'b1;
      ud_t  = $signed({2'b00, idx_ff}) + (down_ff ? -9'sd1 : 9'sd1);
      lfsr_nx = (lfsr_ff >> 1) ^ (lfsr_ff[0] ? marp_pkg::LFSR_TAPS : '0);
      vlen_c = (vlen_ff == '0) ? VLEN_W_L'(1) :
               ((32'(vlen_ff) > VEL_PATTERN_DEPTH) ? VLEN_W_L'(VEL_PATTERN_DEPTH) : vlen_ff);
      ent   = mrsp.rem[2:0];
      vraw  = vpat_ff[7*ent +: 7];
      bits  = held_ff[chunk_ff*8 +: 8];
      pc    = '0;
      seen  = '0;
      hit   = '0;
      for (int j = 0; j < 8; j++) begin
         if (bits[j]) begin
            if (seen == {1'b0, k_ff[2:0]}) hit = 3'(j);
            seen = seen + 1'b1;
         end
      end
      pc    = seen;
      gsum  = marp_pkg::MOD_W'(off_ff) + marp_pkg::MOD_W'(gdur_ff);

      if (ov_ff && rsp_ch.ready) ov_in = 1'b0;

      case (st_ff)
         ST_IDLE: begin
            if (head.valid) begin
               pop = 1'b1;
               case (head.item.op)
                  marp_pkg::OP_NOTE_ON: begin
                     if (head.item.note_ok && !held_ff[nidx]) begin
                        held_in[nidx] = 1'b1;
                        cnt_in = cnt_ff + 1'b1;
                     end
                  end
                  marp_pkg::OP_NOTE_OFF: begin
                     if (!hold_ff && head.item.note_ok) begin
                        if (held_ff[nidx]) cnt_after = cnt_m1;
                        held_in[nidx] = 1'b0;
                        cnt_in = cnt_after;
                        if (cnt_after == '0) begin
                           snd_ok_in = 1'b0;
                           idx_in = '0;
                           down_in = (order_ff == marp_pkg::ORD_DOWN);
                        end
                     end
                  end
                  marp_pkg::OP_CLEAR: begin
                     held_in = '0; cnt_in = '0; idx_in = '0;
                     down_in = (order_ff == marp_pkg::ORD_DOWN);
                     snd_ok_in = 1'b0; accum_in = '0; lfsr_in = marp_pkg::LFSR_SEED;
                  end
                  default: begin
                     n_in = head.item.samples;
                     if (cnt_ff == '0) begin
                        accum_in = '0;
                        if (snd_ok_ff) st_in = ST_EMPTY;
                     end else begin
                        st_in = ST_DUR;
                     end
                  end
               endcase
            end
         end
         ST_EMPTY: begin
            if (out_free) begin
               ov_in = 1'b1; okind_in = 1'b0; onote_in = snd_ff; ovel_in = '0;
               ooff_in = '0; olast_in = 1'b1; snd_ok_in = 1'b0;
               st_in = ST_IDLE;
            end
         end
         ST_DUR: begin
            dur_in = (dnew == '0) ? DW'(1) : dnew;
            sum_in = marp_pkg::MOD_W'(accum_ff) + marp_pkg::MOD_W'(n_ff);
            st_in  = ST_GATE;
         end
         ST_GATE: begin
            gdur_in = DW'((34'(dur_ff) * 34'(gclamp)) >> 8);
            if (n_ff == '0) off_in = '0;
            else if (diff > DW'(nm1)) off_in = OW'(nm1);
            else off_in = OW'(diff);
            st_in = (sum_ff >= marp_pkg::MOD_W'(dur_ff)) ? ST_OFF1 : ST_ACC;
         end
         ST_OFF1: begin
            gated_in = (gsum < marp_pkg::MOD_W'(n_ff));
            if (!snd_ok_ff) begin
               st_in = ST_ADV;
            end else if (out_free) begin
               ov_in = 1'b1; okind_in = 1'b0; onote_in = snd_ff; ovel_in = '0;
               ooff_in = off_ff; olast_in = 1'b0;
               st_in = ST_ADV;
            end
         end
         ST_ADV: begin
            case (order_ff)
               marp_pkg::ORD_UPDOWN: begin
                  if (ud_t >= $signed(9'(cnt_m1))) begin
                     down_in = 1'b1; idx_in = NW'(cnt_m1);
                  end else if (ud_t <= 9'sd0) begin
                     down_in = 1'b0; idx_in = '0;
                  end else begin
                     idx_in = NW'(ud_t);
                  end
                  st_in = ST_POS;
               end
               marp_pkg::ORD_RANDOM: begin
                  lfsr_in = lfsr_nx;
                  mreq.start = 1'b1;
                  mreq.dividend = marp_pkg::MOD_W'(lfsr_nx);
                  mreq.divisor = DW'(cnt_ff);
                  st_in = ST_MODW;
               end
               marp_pkg::ORD_CHORD: begin
                  idx_in = '0;
                  st_in = ST_POS;
               end
               default: begin
                  mreq.start = 1'b1;
                  mreq.dividend = marp_pkg::MOD_W'(idx_ff) + 1'b1;
                  mreq.divisor = DW'(cnt_ff);
                  st_in = ST_MODW;
               end
            endcase
         end
         ST_MODW: begin
            if (mrsp.done) begin
               idx_in = NW'(mrsp.rem);
               st_in = ST_POS;
            end
         end
         ST_POS: begin
            mreq.start = 1'b1;
            mreq.dividend = marp_pkg::MOD_W'(idx_ff);
            mreq.divisor = DW'(vlen_c);
            k_in = (order_ff == marp_pkg::ORD_DOWN) ? NW'(cnt_m1 - CNT_W'(idx_ff)) : idx_ff;
            chunk_in = '0;
            snd_ok_in = 1'b1;
            st_in = ST_VELW;
         end
         ST_VELW: begin
            if (mrsp.done) begin
               vel_in = (vraw == '0) ? 7'd1 : vraw;
               st_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (k_ff < NW'(pc)) begin
               snd_in = NW'({chunk_ff, hit});
               st_in = ST_ON;
            end else begin
               k_in = k_ff - NW'(pc);
               chunk_in = chunk_ff + 1'b1;
            end
         end
         ST_ON: begin
            if (out_free) begin
               ov_in = 1'b1; okind_in = 1'b1; onote_in = snd_ff; ovel_in = vel_ff;
               ooff_in = off_ff; olast_in = !gated_ff;
               st_in = gated_ff ? ST_GOFF : ST_ACC;
            end
         end
         ST_GOFF: begin
            if (out_free) begin
               ov_in = 1'b1; okind_in = 1'b0; onote_in = snd_ff; ovel_in = '0;
               ooff_in = OW'(gsum); olast_in = 1'b1;
               st_in = ST_ACC;
            end
         end
         ST_ACC: begin
            mreq.start = 1'b1;
            mreq.dividend = sum_ff;
            mreq.divisor = dur_ff;
            st_in = ST_ACCW;
         end
         ST_ACCW: begin
            if (mrsp.done) begin
               accum_in = mrsp.rem;
               st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase

      if (csr.we) begin
         case (marp_pkg::csr_idx_type'(csr.index))
            marp_pkg::CSR_ARP_ORDER: begin
               order_in = csr.data[2:0];
               idx_in = '0;
               down_in = (csr.data[2:0] == marp_pkg::ORD_DOWN);
            end
            marp_pkg::CSR_HOLD_NOTES: begin
               if (hold_ff && !csr.data[0]) begin
                  held_in = '0; cnt_in = '0; idx_in = '0;
               end
               hold_in = csr.data[0];
            end
            marp_pkg::CSR_STEP:        step_in  = csr.data[marp_pkg::STEP_W-1:0];
            marp_pkg::CSR_SWING:       swing_in = csr.data[marp_pkg::SWING_W-1:0];
            marp_pkg::CSR_GATE:        gate_in  = csr.data[marp_pkg::GATE_W-1:0];
            marp_pkg::CSR_VEL_LEN:     vlen_in  = csr.data[marp_pkg::VLEN_W-1:0];
            marp_pkg::CSR_VEL_PATTERN: vpat_in  = csr.data[VPW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      n_ff <= n_in; dur_ff <= dur_in; gdur_ff <= gdur_in; sum_ff <= sum_in;
      off_ff <= off_in; gated_ff <= gated_in; chunk_ff <= chunk_in; k_ff <= k_in;
      vel_ff <= vel_in; okind_ff <= okind_in; olast_ff <= olast_in;
      onote_ff <= onote_in; ovel_ff <= ovel_in; ooff_ff <= ooff_in; snd_ff <= snd_in;
      if (reset) begin
         st_ff <= ST_IDLE;
         order_ff <= marp_pkg::ORD_UP; hold_ff <= 1'b0; step_ff <= marp_pkg::STEP_RESET;
         swing_ff <= '0; gate_ff <= marp_pkg::GATE_RESET;
         vlen_ff <= marp_pkg::VLEN_W'(1); vpat_ff <= VPW'(7'd127);
         held_ff <= '0; cnt_ff <= '0; idx_ff <= '0; down_ff <= 1'b0;
         snd_ok_ff <= 1'b0; accum_ff <= '0; lfsr_ff <= marp_pkg::LFSR_SEED;
         ov_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         order_ff <= order_in; hold_ff <= hold_in; step_ff <= step_in;
         swing_ff <= swing_in; gate_ff <= gate_in; vlen_ff <= vlen_in; vpat_ff <= vpat_in;
         held_ff <= held_in; cnt_ff <= cnt_in; idx_ff <= idx_in; down_ff <= down_in;
         snd_ok_ff <= snd_ok_in; accum_ff <= accum_in; lfsr_ff <= lfsr_in;
         ov_ff <= ov_in;
      end
   end

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      32'(cnt_ff) <= NOTE_COUNT)
      else $error("held count out of range");
   a_off_vel: assert property (@(posedge clock) disable iff (reset)
      ov_ff && !okind_ff |-> ovel_ff == '0)
      else $error("note-off with nonzero velocity");
   a_on_vel: assert property (@(posedge clock) disable iff (reset)
      ov_ff && okind_ff |-> ovel_ff != '0)
      else $error("note-on with zero velocity");
   a_lfsr: assert property (@(posedge clock) disable iff (reset)
      lfsr_ff != '0)
      else $error("lfsr locked at zero");
endmodule
`default_nettype wire

// ===== sv/midi_arpeggiator_step.sv =====
// Arpeggiator step engine, top level: front queue, back engine, CSR port.
// Depends on marp_pkg, marp_req_if, marp_rsp_if, marp_front, marp_back.
//
//  channel   dir  handshake      words
//  req_ch    in   valid/ready    note on, note off, block tick, clear
//  rsp_ch    out  valid/ready    note events, last_event marks end of a tick
//  csr_*     in   csr_wr_en      register writes, no read-back
//
// Note on/off and clear are handled in the idle state of the back engine.
// A tick takes 1 to 3 remainder passes plus a scan of up to NOTE_COUNT/8 chunks of the
// held set, and waits while rsp_ch is not ready.
// Synchronous active-high reset; no clearing pass.
// The 2-entry queue keeps taking words, until it is full, while the back engine stalls on rsp_ch.
`default_nettype none
module midi_arpeggiator_step #(
   parameter int NOTE_COUNT        = 128,
   parameter int VEL_PATTERN_DEPTH = 8
) (
   input  wire                                 clock,
   input  wire                                 reset,
   marp_req_if.sink                            req_ch,
   marp_rsp_if.source                          rsp_ch,
   input  wire                                 csr_wr_en,
   input  wire [marp_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire [marp_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   marp_pkg::queue_type head;
   marp_pkg::csr_type   csr;
   logic                pop;

   assign csr.we    = csr_wr_en;
   assign csr.index = csr_index;
   assign csr.data  = csr_wdata;

   marp_front #(.NOTE_COUNT(NOTE_COUNT)) u_front (
      .clock(clock), .reset(reset), .req_ch(req_ch), .pop(pop), .head(head)
   );

   marp_back #(.NOTE_COUNT(NOTE_COUNT), .VEL_PATTERN_DEPTH(VEL_PATTERN_DEPTH)) u_back (
      .clock(clock), .reset(reset), .head(head), .pop(pop), .csr(csr), .rsp_ch(rsp_ch)
   );
endmodule
`default_nettype wire

// ===== verif/tb_midi_arpeggiator_step.sv =====
`timescale 1ns / 100ps
// Testbench for midi_arpeggiator_step: a directed table, then random note, tick and
// clear words under several register settings, each event checked against a predictor.
// Depends on marp_pkg, marp_req_if, marp_rsp_if and the block itself.
module tb_midi_arpeggiator_step;

   localparam int LIMIT = 1000000;
   localparam int DRAIN = 120;

   typedef struct {
      bit       kind;
      bit [6:0] note;
      bit [6:0] vel;
      bit [12:0] off;
      bit       last;
   } ev_type;

   typedef struct {
      marp_pkg::op_type op;
      bit [6:0]  note;
      bit [13:0] samples;
      bit        lit;
      ev_type    ev;
   } row_type;

   logic                            clock;
   logic                            reset;
   logic                            csr_wr_en;
   logic [marp_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [marp_pkg::CSR_DATA_W-1:0] csr_wdata;

   marp_req_if req_ch ();
   marp_rsp_if rsp_ch ();

   midi_arpeggiator_step i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   ev_type pending_ev[$];
   bit     failed;
   int     cycles;
   int     snd_idle;
   int     rcv_idle;

   // arpeggiator image
   bit [127:0]      held;
   int unsigned     idx;
   bit              walk_dn;
   bit              snd_ok;
   bit [6:0]        snd_note;
   longint unsigned accum;
   bit [15:0]       lfsr;
   bit [2:0]        ord;
   bit              hold;
   bit [23:0]       step_len;
   bit [7:0]        swing;
   bit [8:0]        gate;
   bit [3:0]        vlen;
   bit [55:0]       vpat;

   always #2 clock = ~clock;

   function automatic int unsigned held_total();
      int unsigned c;
      c = 0;
      for (int i = 0; i < 128; i++) c += held[i];
      return c;
   endfunction

   function automatic bit [6:0] held_at(int unsigned k);
      int unsigned seen;
      seen = 0;
      for (int i = 0; i < 128; i++) begin
         if (held[i]) begin
            if (seen == k) return i[6:0];
            seen++;
         end
      end
      return 0;
   endfunction

   function automatic void clear_arp();
      held = '0;
      idx = 0;
      walk_dn = (ord == marp_pkg::ORD_DOWN);
      snd_ok = 0;
      snd_note = 0;
      accum = 0;
      lfsr = marp_pkg::LFSR_SEED;
   endfunction

   function automatic void add_ev(bit kind, bit [6:0] nt, bit [6:0] v, longint unsigned off);
      ev_type e;
      e.kind = kind;
      e.note = nt;
      e.vel = v;
      e.off = off[12:0];
      e.last = 0;
      pending_ev.push_back(e);
   endfunction

   function automatic void next_note();
      int unsigned cnt;
      int unsigned pos;
      int          i;
      bit          lsb;
      cnt = held_total();
      if (cnt == 0) begin
         snd_ok = 0;
         return;
      end
      case (ord)
         marp_pkg::ORD_UPDOWN: begin
            i = int'(idx) + (walk_dn ? -1 : 1);
            if (i >= int'(cnt) - 1) begin
               walk_dn = 1;
               i = int'(cnt) - 1;
            end else if (i <= 0) begin
               walk_dn = 0;
               i = 0;
            end
            idx = i;
         end
         marp_pkg::ORD_RANDOM: begin
            lsb = lfsr[0];
            lfsr = lfsr >> 1;
            if (lsb) lfsr ^= marp_pkg::LFSR_TAPS;
            idx = lfsr % cnt;
         end
         marp_pkg::ORD_CHORD: idx = 0;
         default: idx = (idx + 1) % cnt;
      endcase
      pos = (ord == marp_pkg::ORD_DOWN) ? cnt - 1 - idx : idx;
      snd_note = held_at(pos);
      snd_ok = 1;
   endfunction

   function automatic bit [6:0] pick_vel();
      int unsigned len;
      bit [6:0]    v;
      len = vlen;
      if (len < 1) len = 1;
      if (len > 8) len = 8;
      v = 7'(vpat >> (7 * (idx % len)));
      return (v == 0) ? 7'd1 : v;
   endfunction

   function automatic void predict_word(marp_pkg::op_type op, bit [6:0] nt, bit [13:0] ns);
      longint unsigned n, base, dur, g, gd, off;
      int first;
      first = pending_ev.size();
      case (op)
         marp_pkg::OP_NOTE_ON: held[nt] = 1;
         marp_pkg::OP_NOTE_OFF: begin
            if (!hold) begin
               held[nt] = 0;
               if (held == '0) begin
                  snd_ok = 0;
                  idx = 0;
                  walk_dn = (ord == marp_pkg::ORD_DOWN);
               end
            end
         end
         marp_pkg::OP_CLEAR: clear_arp();
         default: begin
            n = (ns > marp_pkg::MAX_BLOCK) ? marp_pkg::MAX_BLOCK : ns;
            if (held == '0) begin
               if (snd_ok) add_ev(0, snd_note, 0, 0);
               snd_ok = 0;
               accum = 0;
            end else begin
               base = (step_len == 0) ? 1 : step_len;
               dur = base;
               if (swing != 0)
                  dur = idx[0] ? (base * (256 + swing)) >> 8 : (base * (256 - swing)) >> 8;
               if (dur < 1) dur = 1;
               g = gate;
               if (g < 1) g = 1;
               if (g > 256) g = 256;
               gd = (dur * g) >> 8;
               if (accum + n >= dur) begin
                  if (n == 0) off = 0;
                  else begin
                     off = (dur > accum) ? dur - accum : 0;
                     if (off > n - 1) off = n - 1;
                  end
                  if (snd_ok) add_ev(0, snd_note, 0, off);
                  next_note();
                  if (snd_ok) begin
                     add_ev(1, snd_note, pick_vel(), off);
                     if (off + gd < n) add_ev(0, snd_note, 0, off + gd);
                  end
               end
               accum = (accum + n) % dur;
            end
         end
      endcase
      if (pending_ev.size() > first) pending_ev[$].last = 1;
   endfunction

   function automatic void apply_reg(marp_pkg::csr_idx_type r, bit [55:0] v);
      case (r)
         marp_pkg::CSR_ARP_ORDER: begin
            ord = v[2:0];
            idx = 0;
            walk_dn = (ord == marp_pkg::ORD_DOWN);
         end
         marp_pkg::CSR_HOLD_NOTES: begin
            if (hold && !v[0]) begin
               held = '0;
               idx = 0;
            end
            hold = v[0];
         end
         marp_pkg::CSR_STEP:    step_len = v[23:0];
         marp_pkg::CSR_SWING:   swing = v[7:0];
         marp_pkg::CSR_GATE:    gate = v[8:0];
         marp_pkg::CSR_VEL_LEN: vlen = v[3:0];
         default:               vpat = v;
      endcase
   endfunction

   task automatic write_reg(marp_pkg::csr_idx_type r, bit [55:0] v);
      csr_wr_en <= 1;
      csr_index <= r;
      csr_wdata <= v;
      @(posedge clock);
      csr_wr_en <= 0;
      apply_reg(r, v);
   endtask

   task automatic send_word(marp_pkg::op_type op, bit [6:0] nt, bit [13:0] ns);
      while ($urandom_range(99) < snd_idle) begin
         req_ch.valid <= 0;
         @(posedge clock);
      end
      req_ch.valid <= 1;
      req_ch.mode <= op;
      req_ch.note_number <= nt;
      req_ch.block_samples <= ns;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predict_word(op, nt, ns);
   endtask

   task automatic settle();
      req_ch.valid <= 0;
      @(posedge clock);
      while (pending_ev.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   task automatic load_regs(int seg);
      bit [55:0] v[7];
      if (seg == 0) v = '{marp_pkg::ORD_UP, 1, 0, 0, 0, 0, 0};
      else if (seg == 1) v = '{7, 0, 24'hFFFFFF, 255, 511, 15, {56{1'b1}}};
      else begin
         v[0] = $urandom_range(7);
         v[1] = $urandom_range(1);
         v[2] = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 3000);
         v[3] = ($urandom_range(2) == 0) ? 0 : $urandom_range(255);
         v[4] = $urandom_range(511);
         v[5] = $urandom_range(15);
         v[6] = {$urandom, $urandom};
      end
      write_reg(marp_pkg::CSR_HOLD_NOTES, v[1]);
      write_reg(marp_pkg::CSR_STEP, v[2]);
      write_reg(marp_pkg::CSR_SWING, v[3]);
      write_reg(marp_pkg::CSR_GATE, v[4]);
      write_reg(marp_pkg::CSR_VEL_LEN, v[5]);
      write_reg(marp_pkg::CSR_VEL_PATTERN, v[6]);
      write_reg(marp_pkg::CSR_ARP_ORDER, v[0]);
   endtask

   task automatic random_word();
      int        r;
      int        s;
      bit [6:0]  nt;
      bit [13:0] ns;
      r = $urandom_range(99);
      nt = ($urandom_range(3) == 0) ? $urandom_range(127) : 48 + $urandom_range(15);
      s = $urandom_range(19);
      if (s == 0) ns = 0;
      else if (s == 1) ns = marp_pkg::MAX_BLOCK;
      else if (s == 2) ns = $urandom_range(16383);
      else ns = $urandom_range(1, 1500);
      if (r < 35) send_word(marp_pkg::OP_NOTE_ON, nt, ns);
      else if (r < 55) send_word(marp_pkg::OP_NOTE_OFF, nt, ns);
      else if (r < 97) send_word(marp_pkg::OP_TICK, nt, ns);
      else send_word(marp_pkg::OP_CLEAR, nt, ns);
   endtask

   always @(posedge clock) begin
      ev_type want;
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("status: fail");
         $finish;
      end else if (reset) begin
         rsp_ch.ready <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_ev.size() == 0) begin
               $display("%0t: unexpected word kind %0d note %0d vel %0d off %0d last %0d",
                        $realtime, rsp_ch.event_kind, rsp_ch.event_note,
                        rsp_ch.event_velocity, rsp_ch.sample_offset, rsp_ch.last_event);
               failed = 1;
            end else begin
               want = pending_ev.pop_front();
               if (rsp_ch.event_kind !== want.kind || rsp_ch.event_note !== want.note ||
                   rsp_ch.event_velocity !== want.vel || rsp_ch.sample_offset !== want.off ||
                   rsp_ch.last_event !== want.last) begin
                  $display({"%0t: expected kind %0d note %0d vel %0d off %0d last %0d,",
                            " got %0d %0d %0d %0d %0d"},
                           $realtime, want.kind, want.note, want.vel, want.off, want.last,
                           rsp_ch.event_kind, rsp_ch.event_note, rsp_ch.event_velocity,
                           rsp_ch.sample_offset, rsp_ch.last_event);
                  failed = 1;
               end
            end
         end
         rsp_ch.ready <= ($urandom_range(99) >= rcv_idle);
      end
   end

   row_type rows[$];

   initial begin
      int mark;
      clock = 0;
      reset = 1;
      snd_idle = 0;
      rcv_idle = 0;
      csr_wr_en = 0;
      csr_index = '0;
      csr_wdata = '0;
      req_ch.valid = 0;
      req_ch.mode = marp_pkg::OP_NOTE_ON;
      req_ch.note_number = '0;
      req_ch.block_samples = '0;
      ord = marp_pkg::ORD_UP;
      hold = 0;
      step_len = marp_pkg::STEP_RESET;
      swing = 0;
      gate = marp_pkg::GATE_RESET;
      vlen = 1;
      vpat = 127;
      clear_arp();

      rows = '{
         '{marp_pkg::OP_NOTE_ON,  60,  0,     0, '{0, 0, 0, 0, 0}},
         '{marp_pkg::OP_TICK,     0,   5512,  1, '{1, 60, 127, 5511, 1}},
         '{marp_pkg::OP_TICK,     0,   16383, 0, '{0, 0, 0, 0, 0}},
         '{marp_pkg::OP_NOTE_ON,  0,   0,     0, '{0, 0, 0, 0, 0}},
         '{marp_pkg::OP_NOTE_ON,  127, 16383, 0, '{0, 0, 0, 0, 0}},
         '{marp_pkg::OP_TICK,     127, 1,     0, '{0, 0, 0, 0, 0}},
         '{marp_pkg::OP_TICK,     0,   0,     0, '{0, 0, 0, 0, 0}},
         '{marp_pkg::OP_TICK,     0,   8192,  0, '{0, 0, 0, 0, 0}},
         '{marp_pkg::OP_NOTE_OFF, 0,   0,     0, '{0, 0, 0, 0, 0}},
         '{marp_pkg::OP_NOTE_OFF, 127, 0,     0, '{0, 0, 0, 0, 0}},
         '{marp_pkg::OP_NOTE_OFF, 60,  0,     0, '{0, 0, 0, 0, 0}},
         '{marp_pkg::OP_TICK,     0,   100,   0, '{0, 0, 0, 0, 0}},
         '{marp_pkg::OP_NOTE_ON,  127, 0,     0, '{0, 0, 0, 0, 0}},
         '{marp_pkg::OP_TICK,     0,   8192,  1, '{1, 127, 127, 5512, 1}},
         '{marp_pkg::OP_CLEAR,    0,   0,     0, '{0, 0, 0, 0, 0}},
         '{marp_pkg::OP_TICK,     0,   8192,  0, '{0, 0, 0, 0, 0}},
         '{marp_pkg::OP_NOTE_ON,  5,   0,     0, '{0, 0, 0, 0, 0}},
         '{marp_pkg::OP_NOTE_ON,  90,  0,     0, '{0, 0, 0, 0, 0}},
         '{marp_pkg::OP_TICK,     0,   8191,  0, '{0, 0, 0, 0, 0}},
         '{marp_pkg::OP_TICK,     0,   5000,  0, '{0, 0, 0, 0, 0}},
         '{marp_pkg::OP_NOTE_OFF, 5,   0,     0, '{0, 0, 0, 0, 0}},
         '{marp_pkg::OP_TICK,     0,   3000,  0, '{0, 0, 0, 0, 0}},
         '{marp_pkg::OP_CLEAR,    127, 16383, 0, '{0, 0, 0, 0, 0}}
      };

      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      foreach (rows[i]) begin
         mark = pending_ev.size();
         send_word(rows[i].op, rows[i].note, rows[i].samples);
         if (rows[i].lit) begin
            if (pending_ev.size() > mark) pending_ev.delete(pending_ev.size() - 1);
            pending_ev.push_back(rows[i].ev);
         end
      end

      for (int ph = 0; ph < 3; ph++) begin
         snd_idle = (ph == 0) ? 28 : (ph == 1) ? 75 : 0;
         rcv_idle = (ph == 0) ? 75 : (ph == 1) ? 28 : 0;
         for (int seg = 0; seg < 2; seg++) begin
            settle();
            load_regs(ph * 2 + seg);
            for (int k = 0; k < 60; k++) random_word();
         end
      end
      settle();

      if (!failed) $display("status: pass");
      else $display("status: fail");
      $finish;
   end
endmodule

// ===== filelist.f =====
sv/marp_pkg.sv
sv/marp_req_if.sv
sv/marp_rsp_if.sv
sv/marp_front.sv
sv/marp_mod.sv
sv/marp_back.sv
sv/midi_arpeggiator_step.sv
verif/tb_midi_arpeggiator_step.sv
